>>> design/sle_pkg.sv
// sle_pkg: shared types, codes and sizing for the sorted list engine.
// No dependencies; imported by sle_cell and sorted_list_engine_top.
`timescale 1ns / 1ps

package sle_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_SORT   = 3'd2,
    OP_SEARCH = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // command broadcast to every cell in a cycle
  typedef enum logic [2:0] {
    CMD_IDLE      = 3'd0,
    CMD_APPEND    = 3'd1,
    CMD_INSERT    = 3'd2,
    CMD_DELETE    = 3'd3,
    CMD_SWAP_EVEN = 3'd4,
    CMD_SWAP_ODD  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
  } sle_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] position;
    logic [4:0] entries_held;
  } sle_out_t;

  // cell to right neighbor
  typedef struct packed {
    logic               held;
    logic               all_lt;
    logic               none_eq;
    logic signed [31:0] value;
  } sle_fwd_t;

  // cell to left neighbor
  typedef struct packed {
    logic               held;
    logic               gt;
    logic signed [31:0] value;
  } sle_bwd_t;

  function automatic logic [4:0] to_field5(input logic [CNT_W-1:0] c);
    logic [CNT_W+4:0] wide;
    wide = {5'd0, c};
    return wide[4:0];
  endfunction

endpackage

>>> design/sle_cell.sv
// sle_cell: one list slot; compares against the operand and its neighbors.
// Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_cell
  import sle_pkg::*;
(
  input  logic               clk,
  input  cmd_t               cmd,
  input  logic signed [31:0] operand,
  input  logic               head,
  input  logic               odd,
  input  logic               held,
  input  sle_fwd_t           fwd_in,
  input  sle_bwd_t           bwd_in,
  output sle_fwd_t           fwd_out,
  output sle_bwd_t           bwd_out,
  output logic               match
);

  logic signed [31:0] value;
  logic signed [31:0] value_next;
  logic signed [31:0] left_value;
  logic               lt;
  logic               eq;
  logic               slot_here;
  logic               pair_right;
  logic               swap_right;

  assign left_value = fwd_in.value;
  assign lt         = value < operand;
  assign eq         = value == operand;
  assign slot_here  = fwd_in.all_lt && !(held && lt);
  assign match      = fwd_in.none_eq && held && eq;

  assign fwd_out.held    = held;
  assign fwd_out.all_lt  = fwd_in.all_lt && held && lt;
  assign fwd_out.none_eq = fwd_in.none_eq && !(held && eq);
  assign fwd_out.value   = value;

  assign bwd_out.held  = held;
  assign bwd_out.gt    = !head && held && (left_value > value);
  assign bwd_out.value = value;

  assign pair_right = (cmd == CMD_SWAP_EVEN && !odd) || (cmd == CMD_SWAP_ODD && odd);
  assign swap_right = bwd_in.held && bwd_in.gt;

  always_comb begin
    value_next = value;
    case (cmd)
      CMD_APPEND: begin
        if (fwd_in.held && !held) value_next = operand;
      end
      CMD_INSERT: begin
        if (slot_here) value_next = operand;
        else if (!fwd_in.all_lt) value_next = left_value;
      end
      CMD_DELETE: begin
        if (match || !fwd_in.none_eq) value_next = bwd_in.value;
      end
      CMD_SWAP_EVEN, CMD_SWAP_ODD: begin
        if (pair_right) begin
          if (swap_right) value_next = bwd_in.value;
        end else begin
          if (bwd_out.gt) value_next = left_value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> design/sorted_list_engine_top.sv
// sorted_list_engine_top: command control, entry count and the row of cells.
// Depends on sle_pkg and sle_cell.
`timescale 1ns / 1ps

// Append, ordered insert, search and delete: each item is accepted with
// start while busy is low, and its result is shown with done for the single
// following cycle, during which the next item may already be accepted. Sort
// runs DEPTH odd-even compare-and-swap passes over the cell row, one pass per
// cycle; busy is high while the passes run and the result appears in the
// cycle after the last pass. done cannot be held off, so the receiver must
// take every result in the cycle it is shown.

module sorted_list_engine_top
  import sle_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  sle_in_t  request,
  output logic     busy,
  output logic     done,
  output sle_out_t result
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             sorting;
  logic [IDX_W-1:0] pass;
  logic             accept;
  logic             full;
  logic             empty;
  logic             found;
  cmd_t             cmd;
  logic             done_next;
  sle_out_t         result_next;
  logic [CNT_W-1:0] pos;
  logic [DEPTH-1:0] held;
  logic [DEPTH-1:0] match;
  sle_fwd_t         fwd [DEPTH+1];
  sle_bwd_t         bwd [DEPTH+1];

  assign busy   = sorting;
  assign accept = start && !sorting;
  assign full   = count == CNT_W'(DEPTH);
  assign empty  = count == '0;
  assign found  = !fwd[DEPTH].none_eq;

  assign fwd[0] = '{held: 1'b1, all_lt: 1'b1, none_eq: 1'b1, value: 32'sd0};
  assign bwd[DEPTH] = '{held: 1'b0, gt: 1'b0, value: 32'sd0};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign held[g] = count > CNT_W'(g);
    sle_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .operand (request.value),
      .head    (g == 0),
      .odd     (g % 2 == 1),
      .held    (held[g]),
      .fwd_in  (fwd[g]),
      .bwd_in  (bwd[g+1]),
      .fwd_out (fwd[g+1]),
      .bwd_out (bwd[g]),
      .match   (match[g])
    );
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) pos = pos | CNT_W'(i + 1);
    end
  end

  always_comb begin
    cmd         = CMD_IDLE;
    count_next  = count;
    done_next   = 1'b0;
    result_next = '{status: ST_OK, position: 5'd0, entries_held: 5'd0};
    if (sorting) begin
      cmd = pass[0] ? CMD_SWAP_ODD : CMD_SWAP_EVEN;
      done_next = pass == IDX_W'(DEPTH - 1);
    end else if (accept) begin
      done_next = request.opcode != OP_SORT;
      case (request.opcode)
        OP_APPEND: begin
          if (full) begin
            result_next.status = ST_FULL;
          end else begin
            cmd = CMD_APPEND;
            count_next = count + 1'b1;
          end
        end
        OP_INSERT: begin
          if (full) begin
            result_next.status = ST_FULL;
          end else begin
            cmd = CMD_INSERT;
            count_next = count + 1'b1;
          end
        end
        OP_SEARCH: begin
          if (found) result_next.position = to_field5(pos);
          else result_next.status = ST_NOT_FOUND;
        end
        OP_DELETE: begin
          if (empty) begin
            result_next.status = ST_EMPTY;
          end else if (!found) begin
            result_next.status = ST_NOT_FOUND;
          end else begin
            cmd = CMD_DELETE;
            count_next = count - 1'b1;
          end
        end
        default: cmd = CMD_IDLE;
      endcase
    end
    result_next.entries_held = to_field5(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sorting <= 1'b0;
      pass    <= '0;
      done    <= 1'b0;
    end else begin
      count <= count_next;
      done  <= done_next;
      if (sorting) begin
        pass <= pass + 1'b1;
        if (pass == IDX_W'(DEPTH - 1)) sorting <= 1'b0;
      end else if (accept && request.opcode == OP_SORT) begin
        sorting <= 1'b1;
        pass    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_no_result_while_sorting: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result shown during sort");

  a_single_cycle_ops: assert property (@(posedge clk) disable iff (rst)
    accept && request.opcode != OP_SORT |=> done)
    else $error("missing result after transfer");

  a_full_holds_count: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_FULL |-> full)
    else $error("full status with list not full");

  a_sort_keeps_count: assert property (@(posedge clk) disable iff (rst)
    sorting |=> $stable(count))
    else $error("count changed during sort");
`endif

endmodule
